>>> rtl/core/cpm_pkg.sv
package cpm_pkg;

   // Default sizes of the datapath
   localparam int COORD_BITS_DEF   = 16;
   localparam int ANGLE_BITS_DEF   = 16;
   localparam int CORDIC_STEPS_DEF = 16;

   // Fraction bits added below the coordinate differences before rotation
   localparam int GUARD_BITS = 24;

   // Entries in the arctangent table; CORDIC_STEPS may not exceed this
   localparam int TABLE_LEN = 24;

   // Result codes
   localparam logic [1:0] OUTCOME_STORED   = 2'd0;
   localparam logic [1:0] OUTCOME_APPENDED = 2'd1;
   localparam logic [1:0] OUTCOME_REPLACED = 2'd2;

   // atan(2^-i) in units of 2^-32 turn, truncated
   localparam logic [31:0] ATAN_TURN32 [TABLE_LEN] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // Table entry rounded half up to angle_bits (2^(angle_bits-1) units per pi)
   function automatic logic [31:0] table_angle(input int idx, input int angle_bits);
      logic [32:0] t;
      t = ({1'b0, ATAN_TURN32[idx]} + (33'd1 << (31 - angle_bits))) >> (32 - angle_bits);
      return t[31:0];
   endfunction

endpackage

>>> rtl/core/collinear_point_merge.sv
// Polyline builder that merges collinear vertices. Each request carries one
// point; each request yields exactly one response telling whether the point
// was stored as one of the first two points of a curve, appended as a new
// vertex, or merged into the last vertex, together with the last vertex now
// held. Directions of the last segment and of the new step are found with a
// CORDIC atan2 on one shared rotation unit, one iteration per cycle, first
// for the last segment and then for the step. A request that starts a curve
// (or arrives with fewer than two points stored) goes from acceptance
// straight to the update state, which loads the response. Any other request
// goes through a setup state plus CORDIC_STEPS iterations for each of the
// two angles, then a compare state and an update state. The next request is
// accepted on the cycle after the response is loaded into the output
// register. A response waiting on rsp_ready does not stop the next request
// from being accepted, only from finishing. The angle tolerance may be
// written through the csr_ port at any time the block is idle; a difference
// strictly below it counts as the same direction.
module collinear_point_merge #(
   parameter int COORD_BITS   = cpm_pkg::COORD_BITS_DEF,
   parameter int ANGLE_BITS   = cpm_pkg::ANGLE_BITS_DEF,
   parameter int CORDIC_STEPS = cpm_pkg::CORDIC_STEPS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [15:0]                  csr_angle_tolerance,

   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_start_new,
   input  logic signed [COORD_BITS-1:0] req_point_x,
   input  logic signed [COORD_BITS-1:0] req_point_y,

   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [1:0]                   rsp_outcome,
   output logic                         rsp_appended,
   output logic signed [COORD_BITS-1:0] rsp_vertex_x,
   output logic signed [COORD_BITS-1:0] rsp_vertex_y
);

   // Width of a coordinate difference
   localparam int DW = COORD_BITS + 1;
   // Rotation datapath: difference, guard bits and headroom for CORDIC gain
   localparam int W  = COORD_BITS + cpm_pkg::GUARD_BITS + 4;
   // Angle accumulator with room above +-pi before saturation
   localparam int ZW = ANGLE_BITS + 2;
   localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   // Width of the tolerance compare
   localparam int TW = (ANGLE_BITS + 1 > 17) ? ANGLE_BITS + 1 : 17;

   localparam logic signed [ZW-1:0] HALF_PI = ZW'(2 ** (ANGLE_BITS - 2));
   localparam logic signed [ZW-1:0] AMAX    = ZW'(2 ** (ANGLE_BITS - 1) - 1);
   localparam logic signed [ZW-1:0] AMIN    = ZW'(-(2 ** (ANGLE_BITS - 1)));
   localparam logic [IW-1:0]        LAST_STEP = IW'(CORDIC_STEPS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_ITER,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   // Sequencer and configuration
   state_type                 state_ff, state_in;
   logic [15:0]               tol_ff, tol_in;
   logic [1:0]                count_ff, count_in;
   logic                      store_ff, store_in;
   logic                      pass_ff, pass_in;
   logic                      merge_ff, merge_in;

   // Held request and polyline vertices
   logic signed [COORD_BITS-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_BITS-1:0] lx_ff, lx_in, ly_ff, ly_in;
   logic signed [COORD_BITS-1:0] ox_ff, ox_in, oy_ff, oy_in;

   // Shared rotation unit
   logic signed [W-1:0]       x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]      z_ff, z_in;
   logic [IW-1:0]             step_ff, step_in;
   logic                      zero_ff, zero_in;
   logic signed [ANGLE_BITS-1:0] ang1_ff, ang1_in, ang2_ff, ang2_in;

   // Output register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_outcome_ff, rsp_outcome_in;
   logic                      rsp_appended_ff, rsp_appended_in;
   logic signed [COORD_BITS-1:0] rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;

   // Combinational helpers
   logic signed [DW-1:0]      dx, dy;
   logic signed [W-1:0]       sx, sy, shx, shy, nx, ny;
   logic [31:0]               tab_full;
   logic signed [ZW-1:0]      tab, nz;
   logic signed [ANGLE_BITS-1:0] ang_sat;
   logic signed [ANGLE_BITS:0]   ang_diff;
   logic [ANGLE_BITS:0]       ang_abs;
   logic                      out_free;

   assign csr_ready    = 1'b1;
   assign req_ready    = (state_ff == ST_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_outcome  = rsp_outcome_ff;
   assign rsp_appended = rsp_appended_ff;
   assign rsp_vertex_x = rsp_x_ff;
   assign rsp_vertex_y = rsp_y_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Difference for the current pass: last segment first, then the new step
   always_comb begin
      if (pass_ff) begin
         dx = {px_ff[COORD_BITS-1], px_ff} - {lx_ff[COORD_BITS-1], lx_ff};
         dy = {py_ff[COORD_BITS-1], py_ff} - {ly_ff[COORD_BITS-1], ly_ff};
      end else begin
         dx = {lx_ff[COORD_BITS-1], lx_ff} - {ox_ff[COORD_BITS-1], ox_ff};
         dy = {ly_ff[COORD_BITS-1], ly_ff} - {oy_ff[COORD_BITS-1], oy_ff};
      end
      sx = {{(W-DW){dx[DW-1]}}, dx} <<< cpm_pkg::GUARD_BITS;
      sy = {{(W-DW){dy[DW-1]}}, dy} <<< cpm_pkg::GUARD_BITS;
   end

   // One CORDIC vectoring iteration
   always_comb begin
      shx      = x_ff >>> step_ff;
      shy      = y_ff >>> step_ff;
      tab_full = cpm_pkg::table_angle(int'(step_ff), ANGLE_BITS);
      tab      = signed'({1'b0, tab_full[ZW-2:0]});
      if (!y_ff[W-1]) begin
         nx = x_ff + shy;
         ny = y_ff - shx;
         nz = z_ff + tab;
      end else begin
         nx = x_ff - shy;
         ny = y_ff + shx;
         nz = z_ff - tab;
      end
      // Clamp to the angle range; a zero vector reads as angle zero
      if (zero_ff) begin
         ang_sat = '0;
      end else if (nz > AMAX) begin
         ang_sat = AMAX[ANGLE_BITS-1:0];
      end else if (nz < AMIN) begin
         ang_sat = AMIN[ANGLE_BITS-1:0];
      end else begin
         ang_sat = nz[ANGLE_BITS-1:0];
      end
   end

   // Absolute angle difference, no wrap at +-pi
   always_comb begin
      ang_diff = {ang1_ff[ANGLE_BITS-1], ang1_ff} - {ang2_ff[ANGLE_BITS-1], ang2_ff};
      ang_abs  = ang_diff[ANGLE_BITS] ? unsigned'(-ang_diff) : unsigned'(ang_diff);
   end

   // Next-state logic
   always_comb begin
      state_in        = state_ff;
      tol_in          = tol_ff;
      count_in        = count_ff;
      store_in        = store_ff;
      pass_in         = pass_ff;
      merge_in        = merge_ff;
      px_in           = px_ff;
      py_in           = py_ff;
      lx_in           = lx_ff;
      ly_in           = ly_ff;
      ox_in           = ox_ff;
      oy_in           = oy_ff;
      x_in            = x_ff;
      y_in            = y_ff;
      z_in            = z_ff;
      step_in         = step_ff;
      zero_in         = zero_ff;
      ang1_in         = ang1_ff;
      ang2_in         = ang2_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_outcome_in  = rsp_outcome_ff;
      rsp_appended_in = rsp_appended_ff;
      rsp_x_in        = rsp_x_ff;
      rsp_y_in        = rsp_y_ff;

      if (csr_valid && csr_ready) begin
         tol_in = csr_angle_tolerance;
      end

      // Drop the response once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               px_in   = req_point_x;
               py_in   = req_point_y;
               pass_in = 1'b0;
               if (req_start_new) begin
                  count_in = '0;
               end
               if (req_start_new || count_ff < 2'd2) begin
                  store_in = 1'b1;
                  state_in = ST_UPDATE;
               end else begin
                  store_in = 1'b0;
                  state_in = ST_PREP;
               end
            end
         end
         ST_PREP: begin
            // Turn a left-half vector into the right half before iterating
            zero_in = (dx == '0) && (dy == '0);
            step_in = '0;
            if (sx[W-1]) begin
               if (!sy[W-1]) begin
                  x_in = sy;
                  y_in = -sx;
                  z_in = HALF_PI;
               end else begin
                  x_in = -sy;
                  y_in = sx;
                  z_in = -HALF_PI;
               end
            end else begin
               x_in = sx;
               y_in = sy;
               z_in = '0;
            end
            state_in = ST_ITER;
         end
         ST_ITER: begin
            x_in    = nx;
            y_in    = ny;
            z_in    = nz;
            step_in = step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               if (pass_ff) begin
                  ang2_in  = ang_sat;
                  state_in = ST_COMPARE;
               end else begin
                  ang1_in  = ang_sat;
                  pass_in  = 1'b1;
                  state_in = ST_PREP;
               end
            end
         end
         ST_COMPARE: begin
            merge_in = TW'(ang_abs) < TW'(tol_ff);
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            // Hold here until the output register is free
            if (out_free) begin
               lx_in        = px_ff;
               ly_in        = py_ff;
               rsp_valid_in = 1'b1;
               rsp_x_in     = px_ff;
               rsp_y_in     = py_ff;
               if (store_ff) begin
                  ox_in           = lx_ff;
                  oy_in           = ly_ff;
                  count_in        = count_ff + 1'b1;
                  rsp_outcome_in  = cpm_pkg::OUTCOME_STORED;
                  rsp_appended_in = 1'b0;
               end else if (merge_ff) begin
                  rsp_outcome_in  = cpm_pkg::OUTCOME_REPLACED;
                  rsp_appended_in = 1'b0;
               end else begin
                  ox_in           = lx_ff;
                  oy_in           = ly_ff;
                  rsp_outcome_in  = cpm_pkg::OUTCOME_APPENDED;
                  rsp_appended_in = 1'b1;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= 16'd1;
         count_ff     <= '0;
         lx_ff        <= '0;
         ly_ff        <= '0;
         ox_ff        <= '0;
         oy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         count_ff     <= count_in;
         lx_ff        <= lx_in;
         ly_ff        <= ly_in;
         ox_ff        <= ox_in;
         oy_ff        <= oy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      store_ff        <= store_in;
      pass_ff         <= pass_in;
      merge_ff        <= merge_in;
      px_ff           <= px_in;
      py_ff           <= py_in;
      x_ff            <= x_in;
      y_ff            <= y_in;
      z_ff            <= z_in;
      step_ff         <= step_in;
      zero_ff         <= zero_in;
      ang1_ff         <= ang1_in;
      ang2_ff         <= ang2_in;
      rsp_outcome_ff  <= rsp_outcome_in;
      rsp_appended_ff <= rsp_appended_in;
      rsp_x_ff        <= rsp_x_in;
      rsp_y_ff        <= rsp_y_in;
   end

endmodule
